FILE: sv/frame_difference_motion_detector_macros.svh
// Assertion macros for the frame difference motion detector.
// Included by the top level; depends on nothing else.
`ifndef FRAME_DIFFERENCE_MOTION_DETECTOR_MACROS_SVH
`define FRAME_DIFFERENCE_MOTION_DETECTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FDMD_ASSERT_SAME(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FDMD_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: sv/fdmd_pkg.sv
// Shared types and constants of the frame difference motion detector.
// Used by every module of the block; depends on nothing.
package fdmd_pkg;

    localparam int unsigned MAX_PIXELS = 16384;
    localparam int unsigned NUM_BANDS  = 10;

    localparam int unsigned IDX_W   = $clog2(MAX_PIXELS);
    localparam int unsigned CNT_W   = 15;
    localparam int unsigned BAND_W  = 4;
    localparam int unsigned SUM_W   = 22;
    localparam int unsigned RUN_W   = 16;
    localparam int unsigned PROD_W  = 18;
    localparam int unsigned RPROD_W = 38;
    localparam int unsigned THR_W   = 11;
    localparam int unsigned NUM_W   = 29;
    localparam int unsigned DEN_W   = 22;
    localparam int unsigned LIGHT_W = 7;

    localparam int unsigned SENS_MAX  = 10;
    localparam int unsigned SENS_BASE = 11;
    localparam int unsigned PCT_SCALE = 100;
    localparam int unsigned PIX_WHITE = 255;

    // Reciprocals for exact division of small values by constants.
    localparam int unsigned RECIP_BAND_SHIFT = 23;
    localparam int unsigned RECIP_BAND = (2**RECIP_BAND_SHIFT + NUM_BANDS - 1) / NUM_BANDS;
    localparam int unsigned RECIP_PCT_SHIFT  = 26;
    localparam int unsigned RECIP_PCT  = (2**RECIP_PCT_SHIFT + PCT_SCALE - 1) / PCT_SCALE;

    localparam logic [CNT_W-1:0] TALLY_MAX = '1;
    localparam logic [RUN_W-1:0] RUN_MAX   = '1;

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QLVL_W = $clog2(QDEPTH + 1);

    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned SETTLE_W      = 3;

    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THRESHOLD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_FRAMES    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_FRAMES     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_SWITCH     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BAND       = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BAND         = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT      = 4'd7;

    typedef struct packed {
        logic [7:0]        change_threshold;
        logic [RUN_W-1:0]  motion_frames;
        logic [RUN_W-1:0]  night_frames;
        logic [6:0]        night_switch;
        logic [3:0]        sensitivity;
        logic [BAND_W-1:0] start_band;
        logic [BAND_W-1:0] end_band;
        logic [CNT_W-1:0]  pixel_count;
    } cfg_t;

    // Totals of one finished frame, handed from the front to the back.
    typedef struct packed {
        logic [CNT_W-1:0] tally;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] n;
        logic [THR_W-1:0] thr;
    } frame_rec_t;

    typedef struct packed {
        logic [CNT_W-1:0]   changed_pixels;
        logic [LIGHT_W-1:0] light_level;
        logic               night;
        logic               motion_active;
        logic               motion;
    } result_t;

endpackage

FILE: sv/frame_difference_motion_detector.sv
// Pixels are taken one per cycle within a frame unless input is held off; a register write holds
// input off until the derived bounds settle. The result of a frame passes through the queue,
// the light level divider and the decision state after its last pixel transfer.
// The back part takes one frame at a time; a two-frame queue absorbs short frames.
// Reset clears all control state and loads the default configuration; the previous frame reads
// as zero until each position is written, tracked by a fill mark, so no clearing pass is needed.
// Top level of the frame difference motion detector: configuration registers and wiring.
// Depends on fdmd_pkg, fdmd_front, fdmd_fifo, fdmd_back and the assertion macro header.
`include "frame_difference_motion_detector_macros.svh"

module frame_difference_motion_detector (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [7:0] pixel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] motion, [1] motion_active, [2] night, [9:3] light_level, [24:10] changed_pixels
    output logic [31:0]                         m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fdmd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fdmd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    fdmd_pkg::cfg_t              cfg_reg;
    fdmd_pkg::frame_rec_t        q_wr;
    fdmd_pkg::frame_rec_t        q_rd;
    fdmd_pkg::result_t           result;
    logic                        q_push;
    logic                        q_pop;
    logic [fdmd_pkg::QLVL_W-1:0] q_level;
    logic                        cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.change_threshold <= 8'd15;
            cfg_reg.motion_frames    <= 16'd5;
            cfg_reg.night_frames     <= 16'd10;
            cfg_reg.night_switch     <= 7'd20;
            cfg_reg.sensitivity      <= 4'd8;
            cfg_reg.start_band       <= 4'd3;
            cfg_reg.end_band         <= 4'd8;
            cfg_reg.pixel_count      <= 15'd2304;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fdmd_pkg::CFG_CHANGE_THRESHOLD: cfg_reg.change_threshold <= cfg_data[7:0];
                fdmd_pkg::CFG_MOTION_FRAMES:    cfg_reg.motion_frames    <= cfg_data[15:0];
                fdmd_pkg::CFG_NIGHT_FRAMES:     cfg_reg.night_frames     <= cfg_data[15:0];
                fdmd_pkg::CFG_NIGHT_SWITCH:     cfg_reg.night_switch     <= cfg_data[6:0];
                fdmd_pkg::CFG_SENSITIVITY:      cfg_reg.sensitivity      <= cfg_data[3:0];
                fdmd_pkg::CFG_START_BAND:       cfg_reg.start_band       <= cfg_data[3:0];
                fdmd_pkg::CFG_END_BAND:         cfg_reg.end_band         <= cfg_data[3:0];
                fdmd_pkg::CFG_PIXEL_COUNT:      cfg_reg.pixel_count      <= cfg_data[14:0];
                default:
                begin
                end
            endcase
        end
    end

    fdmd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cfg_write (cfg_write),
        .pix_valid (s_axis_tvalid),
        .pix_ready (s_axis_tready),
        .pix       (s_axis_tdata),
        .q_level   (q_level),
        .push      (q_push),
        .rec       (q_wr)
    );

    fdmd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wr    (q_wr),
        .pop   (q_pop),
        .rd    (q_rd),
        .level (q_level)
    );

    fdmd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_level != '0),
        .q_pop     (q_pop),
        .rec       (q_rd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (result)
    );

    assign m_axis_tdata = {7'd0, result};

    // A register write must hold off pixel transfers while the bounds settle.
    `FDMD_ASSERT_NEXT(a_cfg_holds_input, clk, rst_n, cfg_write, !s_axis_tready)
    // The front reserves queue space before it takes a pixel that ends a frame.
    `FDMD_ASSERT_SAME(a_push_not_full, clk, rst_n, q_push,
                      q_level != fdmd_pkg::QLVL_W'(fdmd_pkg::QDEPTH))
    // The back only takes frame totals that are there.
    `FDMD_ASSERT_SAME(a_pop_not_empty, clk, rst_n, q_pop, q_level != '0)

endmodule

FILE: sv/fdmd_front.sv
// Front part: accepts pixels, compares them with the stored frame and tallies a frame.
// Holds the previous-frame memory and the region bounds; uses fdmd_pkg.
module fdmd_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fdmd_pkg::cfg_t                  cfg,
    input  logic                            cfg_write,
    input  logic                            pix_valid,
    output logic                            pix_ready,
    input  logic [7:0]                      pix,
    input  logic [fdmd_pkg::QLVL_W-1:0]     q_level,
    output logic                            push,
    output fdmd_pkg::frame_rec_t            rec
);

    logic [7:0] mem [fdmd_pkg::MAX_PIXELS];

    logic [fdmd_pkg::CNT_W-1:0]   n_c;
    logic [fdmd_pkg::BAND_W-1:0]  sb_c;
    logic [fdmd_pkg::BAND_W-1:0]  eb_c;
    logic [fdmd_pkg::BAND_W-1:0]  s_c;
    logic [fdmd_pkg::CNT_W-1:0]   size_c;
    logic [fdmd_pkg::RPROD_W-1:0] lo_prod;
    logic [fdmd_pkg::RPROD_W-1:0] hi_prod;
    logic [fdmd_pkg::RPROD_W-1:0] thr_prod;

    // Region bounds and motion threshold, recomputed each cycle from the registers.
    logic [fdmd_pkg::CNT_W-1:0]  n1_reg;
    logic [fdmd_pkg::PROD_W-1:0] plo_reg;
    logic [fdmd_pkg::PROD_W-1:0] phi_reg;
    logic [fdmd_pkg::BAND_W-1:0] sfac_reg;
    logic [fdmd_pkg::CNT_W-1:0]  lo_reg;
    logic [fdmd_pkg::CNT_W-1:0]  hi_reg;
    logic [fdmd_pkg::BAND_W-1:0] sfac2_reg;
    logic [fdmd_pkg::PROD_W-1:0] sp_reg;
    logic [fdmd_pkg::THR_W-1:0]  thr_reg;

    logic [fdmd_pkg::SETTLE_W-1:0] settle_reg;
    logic [fdmd_pkg::IDX_W-1:0]    idx_reg;
    logic [fdmd_pkg::IDX_W-1:0]    idx_next;
    logic [fdmd_pkg::CNT_W-1:0]    fill_reg;
    logic [fdmd_pkg::CNT_W-1:0]    fill_next;
    logic [fdmd_pkg::CNT_W-1:0]    idx_w;
    logic [fdmd_pkg::CNT_W-1:0]    idx_inc;
    logic                          accept;
    logic                          last_c;
    logic                          roi_c;

    logic       s1_valid_reg;
    logic       s1_last_reg;
    logic       s1_roi_reg;
    logic       s1_ok_reg;
    logic [7:0] s1_px_reg;
    logic [7:0] s1_thr_reg;
    logic [7:0] rd_reg;

    logic [fdmd_pkg::CNT_W-1:0] tally_reg;
    logic [fdmd_pkg::SUM_W-1:0] sum_reg;
    logic [fdmd_pkg::CNT_W-1:0] tally_sum;
    logic [fdmd_pkg::SUM_W-1:0] sum_sum;
    logic [7:0]                 old_px;
    logic [7:0]                 diff;
    logic                       hit;
    logic [fdmd_pkg::QLVL_W:0]  occupancy;

    function automatic logic [fdmd_pkg::BAND_W-1:0] clamp_band(
        input logic [fdmd_pkg::BAND_W-1:0] b
    );
        logic [fdmd_pkg::BAND_W-1:0] r;
        begin
            r = b;
            if (b == '0)
            begin
                r = fdmd_pkg::BAND_W'(1);
            end
            else if (b > fdmd_pkg::BAND_W'(fdmd_pkg::NUM_BANDS))
            begin
                r = fdmd_pkg::BAND_W'(fdmd_pkg::NUM_BANDS);
            end
            return r;
        end
    endfunction

    always_comb
    begin
        if (cfg.pixel_count == '0)
        begin
            n_c = fdmd_pkg::CNT_W'(1);
        end
        else if (cfg.pixel_count > fdmd_pkg::CNT_W'(fdmd_pkg::MAX_PIXELS))
        begin
            n_c = fdmd_pkg::CNT_W'(fdmd_pkg::MAX_PIXELS);
        end
        else
        begin
            n_c = cfg.pixel_count;
        end
        sb_c = clamp_band(cfg.start_band);
        eb_c = clamp_band(cfg.end_band);
        if (cfg.sensitivity > fdmd_pkg::BAND_W'(fdmd_pkg::SENS_MAX))
        begin
            s_c = fdmd_pkg::BAND_W'(fdmd_pkg::SENS_MAX);
        end
        else
        begin
            s_c = cfg.sensitivity;
        end
        size_c   = (hi_reg > lo_reg) ? (hi_reg - lo_reg) : '0;
        lo_prod  = fdmd_pkg::RPROD_W'(plo_reg) * fdmd_pkg::RPROD_W'(fdmd_pkg::RECIP_BAND);
        hi_prod  = fdmd_pkg::RPROD_W'(phi_reg) * fdmd_pkg::RPROD_W'(fdmd_pkg::RECIP_BAND);
        thr_prod = fdmd_pkg::RPROD_W'(sp_reg) * fdmd_pkg::RPROD_W'(fdmd_pkg::RECIP_PCT);
    end

    always_ff @(posedge clk)
    begin
        n1_reg    <= n_c;
        plo_reg   <= fdmd_pkg::PROD_W'(n_c) * fdmd_pkg::PROD_W'(sb_c - fdmd_pkg::BAND_W'(1));
        phi_reg   <= fdmd_pkg::PROD_W'(n_c) * fdmd_pkg::PROD_W'(eb_c);
        sfac_reg  <= fdmd_pkg::BAND_W'(fdmd_pkg::SENS_BASE) - s_c;
        lo_reg    <= lo_prod[fdmd_pkg::RECIP_BAND_SHIFT +: fdmd_pkg::CNT_W];
        hi_reg    <= hi_prod[fdmd_pkg::RECIP_BAND_SHIFT +: fdmd_pkg::CNT_W];
        sfac2_reg <= sfac_reg;
        sp_reg    <= fdmd_pkg::PROD_W'(size_c) * fdmd_pkg::PROD_W'(sfac2_reg);
        thr_reg   <= thr_prod[fdmd_pkg::RECIP_PCT_SHIFT +: fdmd_pkg::THR_W];
    end

    // Input waits until the derived values have caught up with a register write,
    // and while every queue slot is spoken for.
    assign occupancy = fdmd_pkg::QLVL_W'(q_level) + (fdmd_pkg::QLVL_W + 1)'(s1_valid_reg
                       && s1_last_reg);
    assign pix_ready = (settle_reg == '0)
                       && (occupancy < (fdmd_pkg::QLVL_W + 1)'(fdmd_pkg::QDEPTH));
    assign accept    = pix_valid && pix_ready;

    always_comb
    begin
        idx_w   = fdmd_pkg::CNT_W'(idx_reg);
        idx_inc = idx_w + fdmd_pkg::CNT_W'(1);
        last_c  = idx_inc >= n1_reg;
        roi_c   = (idx_w > lo_reg) && (idx_w < hi_reg);
        idx_next  = last_c ? '0 : idx_inc[fdmd_pkg::IDX_W-1:0];
        fill_next = (idx_inc > fill_reg) ? idx_inc : fill_reg;
    end

    // Indexes always run upward from zero, so the written entries form a prefix
    // below the fill mark; anything at or above it is unwritten and is read as zero.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg       <= mem[idx_reg];
            mem[idx_reg] <= pix;
            s1_px_reg    <= pix;
            s1_thr_reg   <= cfg.change_threshold;
            s1_last_reg  <= last_c;
            s1_roi_reg   <= roi_c;
            s1_ok_reg    <= idx_w < fill_reg;
        end
    end

    always_comb
    begin
        old_px    = s1_ok_reg ? rd_reg : 8'd0;
        diff      = (s1_px_reg > old_px) ? (s1_px_reg - old_px) : (old_px - s1_px_reg);
        hit       = (diff > s1_thr_reg) && s1_roi_reg && (tally_reg != fdmd_pkg::TALLY_MAX);
        tally_sum = tally_reg + fdmd_pkg::CNT_W'(hit);
        sum_sum   = sum_reg + fdmd_pkg::SUM_W'(s1_px_reg);
    end

    assign push      = s1_valid_reg && s1_last_reg;
    assign rec.tally = tally_sum;
    assign rec.sum   = sum_sum;
    assign rec.n     = n1_reg;
    assign rec.thr   = thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg   <= fdmd_pkg::SETTLE_W'(fdmd_pkg::SETTLE_CYCLES);
            idx_reg      <= '0;
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
            tally_reg    <= '0;
            sum_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                settle_reg <= fdmd_pkg::SETTLE_W'(fdmd_pkg::SETTLE_CYCLES);
            end
            else if (settle_reg != '0)
            begin
                settle_reg <= settle_reg - fdmd_pkg::SETTLE_W'(1);
            end
            if (accept)
            begin
                idx_reg  <= idx_next;
                fill_reg <= fill_next;
            end
            s1_valid_reg <= accept;
            if (s1_valid_reg)
            begin
                if (s1_last_reg)
                begin
                    tally_reg <= '0;
                    sum_reg   <= '0;
                end
                else
                begin
                    tally_reg <= tally_sum;
                    sum_reg   <= sum_sum;
                end
            end
        end
    end

endmodule

FILE: sv/fdmd_fifo.sv
// Short queue of finished frame totals between the front and the back.
// Uses the record type of fdmd_pkg.
module fdmd_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  fdmd_pkg::frame_rec_t        wr,
    input  logic                        pop,
    output fdmd_pkg::frame_rec_t        rd,
    output logic [fdmd_pkg::QLVL_W-1:0] level
);

    fdmd_pkg::frame_rec_t slot [fdmd_pkg::QDEPTH];

    logic [fdmd_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [fdmd_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [fdmd_pkg::QLVL_W-1:0] level_reg;

    function automatic logic [fdmd_pkg::QPTR_W-1:0] bump(
        input logic [fdmd_pkg::QPTR_W-1:0] p
    );
        begin
            if (p == fdmd_pkg::QPTR_W'(fdmd_pkg::QDEPTH - 1))
            begin
                return '0;
            end
            return p + fdmd_pkg::QPTR_W'(1);
        end
    endfunction

    assign rd    = slot[rd_ptr_reg];
    assign level = level_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot[wr_ptr_reg] <= wr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + fdmd_pkg::QLVL_W'(1);
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - fdmd_pkg::QLVL_W'(1);
            end
        end
    end

endmodule

FILE: sv/fdmd_back.sv
// Back part: per-frame light level division, motion and night decisions, result register.
// Takes frame totals from the queue; uses fdmd_pkg.
module fdmd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fdmd_pkg::cfg_t       cfg,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  fdmd_pkg::frame_rec_t rec,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fdmd_pkg::result_t    result
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_DECIDE
    } back_state_t;

    localparam int unsigned STEP_W = $clog2(fdmd_pkg::NUM_W);

    back_state_t state_reg;

    logic [fdmd_pkg::NUM_W-1:0]  num_reg;
    logic [fdmd_pkg::DEN_W-1:0]  rem_reg;
    logic [fdmd_pkg::DEN_W-1:0]  den_reg;
    logic [STEP_W-1:0]           cnt_reg;
    logic [fdmd_pkg::CNT_W-1:0]  tally_reg;
    logic [fdmd_pkg::THR_W-1:0]  thr_reg;
    logic [fdmd_pkg::RUN_W-1:0]  motion_run_reg;
    logic                        motion_flag_reg;
    logic [fdmd_pkg::RUN_W-1:0]  night_run_reg;
    logic                        night_flag_reg;
    logic                        out_valid_reg;
    fdmd_pkg::result_t           result_reg;

    logic [fdmd_pkg::DEN_W:0]    rem_w;
    logic                        q_bit;
    logic [fdmd_pkg::DEN_W-1:0]  rem_next;
    logic [fdmd_pkg::NUM_W-1:0]  light;
    logic [fdmd_pkg::NUM_W-1:0]  ns_w;
    logic [fdmd_pkg::RUN_W-1:0]  nrun_n;
    logic                        nflag_n;
    logic [fdmd_pkg::RUN_W-1:0]  mrun_n;
    logic                        mflag_n;
    logic                        can_emit;

    assign q_pop     = (state_reg == B_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign can_emit  = !out_valid_reg || out_ready;

    // One quotient bit per step: the numerator shifts out at the top while the
    // quotient fills in at the bottom of the same register.
    always_comb
    begin
        rem_w    = {rem_reg, num_reg[fdmd_pkg::NUM_W-1]};
        q_bit    = rem_w >= (fdmd_pkg::DEN_W + 1)'(den_reg);
        rem_next = q_bit ? fdmd_pkg::DEN_W'(rem_w - (fdmd_pkg::DEN_W + 1)'(den_reg))
                         : rem_w[fdmd_pkg::DEN_W-1:0];
    end

    always_comb
    begin
        light   = num_reg;
        ns_w    = fdmd_pkg::NUM_W'(cfg.night_switch);
        nrun_n  = night_run_reg;
        nflag_n = night_flag_reg;
        if (night_flag_reg)
        begin
            if (light > ns_w)
            begin
                if (night_run_reg != '0)
                begin
                    nrun_n = night_run_reg - fdmd_pkg::RUN_W'(1);
                end
                if (nrun_n == '0)
                begin
                    nflag_n = 1'b0;
                end
            end
        end
        else if (light < ns_w)
        begin
            if (night_run_reg != fdmd_pkg::RUN_MAX)
            begin
                nrun_n = night_run_reg + fdmd_pkg::RUN_W'(1);
            end
            if (nrun_n > cfg.night_frames)
            begin
                nflag_n = 1'b1;
            end
        end

        mrun_n  = motion_run_reg;
        mflag_n = motion_flag_reg;
        if (tally_reg > fdmd_pkg::CNT_W'(thr_reg))
        begin
            if (motion_run_reg != fdmd_pkg::RUN_MAX)
            begin
                mrun_n = motion_run_reg + fdmd_pkg::RUN_W'(1);
            end
            if (!motion_flag_reg && (mrun_n >= cfg.motion_frames))
            begin
                mflag_n = 1'b1;
            end
        end
        else if (motion_flag_reg)
        begin
            mrun_n  = '0;
            mflag_n = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_IDLE;
            motion_run_reg  <= '0;
            motion_flag_reg <= 1'b0;
            night_run_reg   <= '0;
            night_flag_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            num_reg         <= '0;
            rem_reg         <= '0;
            den_reg         <= '0;
            cnt_reg         <= '0;
            tally_reg       <= '0;
            thr_reg         <= '0;
            result_reg      <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        num_reg   <= fdmd_pkg::NUM_W'(rec.sum)
                                     * fdmd_pkg::NUM_W'(fdmd_pkg::PCT_SCALE);
                        den_reg   <= fdmd_pkg::DEN_W'(rec.n)
                                     * fdmd_pkg::DEN_W'(fdmd_pkg::PIX_WHITE);
                        rem_reg   <= '0;
                        cnt_reg   <= STEP_W'(fdmd_pkg::NUM_W - 1);
                        tally_reg <= rec.tally;
                        thr_reg   <= rec.thr;
                        state_reg <= B_DIV;
                    end
                end
                B_DIV:
                begin
                    num_reg <= {num_reg[fdmd_pkg::NUM_W-2:0], q_bit};
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg - STEP_W'(1);
                    if (cnt_reg == '0)
                    begin
                        state_reg <= B_DECIDE;
                    end
                end
                B_DECIDE:
                begin
                    if (can_emit)
                    begin
                        night_run_reg             <= nrun_n;
                        night_flag_reg            <= nflag_n;
                        motion_run_reg            <= mrun_n;
                        motion_flag_reg           <= mflag_n;
                        result_reg.motion         <= mflag_n && !nflag_n;
                        result_reg.motion_active  <= mflag_n;
                        result_reg.night          <= nflag_n;
                        result_reg.light_level    <= light[fdmd_pkg::LIGHT_W-1:0];
                        result_reg.changed_pixels <= tally_reg;
                        out_valid_reg             <= 1'b1;
                        state_reg                 <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule
